>>> src/nested_uleb128_reference_parser_defines.svh
// ----------------------------------------------------------------------------
// nested uleb128 reference parser: assertion macros
// checks written as same-cycle or next-cycle implications under reset
// ----------------------------------------------------------------------------
`ifndef NESTED_ULEB128_REFERENCE_PARSER_DEFINES_SVH
`define NESTED_ULEB128_REFERENCE_PARSER_DEFINES_SVH

// same-cycle implication
`define NULRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NULRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/nulrp_pkg.sv
// ----------------------------------------------------------------------------
// nulrp_pkg
// shared types, codes and constants of the nested uleb128 reference parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nulrp_pkg;

  localparam logic [7:0]  FORMAT_MARKER = 8'h7F;
  localparam logic [63:0] KIND_MAX      = 64'd13;
  localparam logic [6:0]  SHIFT_STEP    = 7'd7;
  localparam logic [6:0]  SHIFT_MAX     = 7'd63;
  localparam int          QUEUE_DEPTH   = 2;

  typedef enum logic [3:0] {
    PH_MARKER      = 4'd0,
    PH_PAIR_COUNT  = 4'd1,
    PH_SRC_SECT    = 4'd2,
    PH_TGT_SECT    = 4'd3,
    PH_TGT_COUNT   = 4'd4,
    PH_TGT_DELTA   = 4'd5,
    PH_KIND_COUNT  = 4'd6,
    PH_KIND        = 4'd7,
    PH_DELTA_COUNT = 4'd8,
    PH_SRC_DELTA   = 4'd9,
    PH_DONE        = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_FINISHED  = 3'd1,
    ST_NO_MARKER = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_BAD_KIND  = 3'd4
  } status_t;

  // one classified event from the front
  typedef struct packed {
    logic        marker;
    logic        marker_ok;
    logic        overflow;
    logic        num_done;
    logic        last;
    logic [63:0] value;
  } token_t;

endpackage

>>> src/nulrp_if.sv
// ----------------------------------------------------------------------------
// nulrp channel interfaces
// byte input channel and reference result channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nulrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nulrp_out_if;
  logic        valid;
  logic        ready;
  logic        has_entry;
  logic [2:0]  status;
  logic [3:0]  ref_kind;
  logic [7:0]  source_section;
  logic [7:0]  target_section;
  logic [63:0] source_offset;
  logic [63:0] target_offset;

  modport source (output valid, output has_entry, output status, output ref_kind,
                  output source_section, output target_section,
                  output source_offset, output target_offset, input ready);
  modport sink   (input valid, input has_entry, input status, input ref_kind,
                  input source_section, input target_section,
                  input source_offset, input target_offset, output ready);
endinterface

>>> src/nulrp_front.sv
// ----------------------------------------------------------------------------
// nulrp_front
// takes one byte a beat, assembles uleb128 numbers and classifies events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nulrp_front (
  input  logic                clk,
  input  logic                rst_n,
  nulrp_in_if.sink            in_chan,
  input  logic                q_ready,
  output logic                tok_push,
  output nulrp_pkg::token_t   tok,
  output logic                expect_marker
);
  import nulrp_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic        first_r, first_nxt;
  logic        accept;
  logic [63:0] acc_new;

  assign in_chan.ready = q_ready;
  assign accept        = in_chan.valid && q_ready;
  assign expect_marker = first_r;
  assign acc_new       = acc_r | (64'(in_chan.data_byte[6:0]) << shift_r);

  always_comb begin
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    first_nxt = first_r;
    tok       = '0;
    tok.last  = in_chan.last_byte;
    if (first_r) begin
      tok.marker    = 1'b1;
      tok.marker_ok = (in_chan.data_byte == FORMAT_MARKER);
      first_nxt     = 1'b0;
    end else if (shift_r > SHIFT_MAX) begin
      tok.overflow = 1'b1;
    end else if (!in_chan.data_byte[7]) begin
      tok.num_done = 1'b1;
      tok.value    = acc_new;
      acc_nxt      = '0;
      shift_nxt    = '0;
    end else begin
      acc_nxt   = acc_new;
      shift_nxt = shift_r + SHIFT_STEP;
    end
    // end of stream re-arms
    if (in_chan.last_byte) begin
      acc_nxt   = '0;
      shift_nxt = '0;
      first_nxt = 1'b1;
    end
    tok_push = accept && (tok.marker || tok.overflow || tok.num_done || tok.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
      first_r <= 1'b1;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

>>> src/nulrp_queue.sv
// ----------------------------------------------------------------------------
// nulrp_queue
// short token queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nulrp_queue #(
  parameter int Depth = nulrp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nulrp_pkg::token_t push_tok,
  output logic              not_full,
  output logic              head_valid,
  output nulrp_pkg::token_t head_tok,
  input  logic              pop
);
  import nulrp_pkg::*;

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] Full     = CountW'(Depth);

  token_t            mem_r [Depth];
  logic [AddrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r;
  logic              do_push, do_pop;

  assign not_full   = (count_r != Full);
  assign head_valid = (count_r != '0);
  assign head_tok   = mem_r[rd_ptr_r];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastAddr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastAddr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

>>> src/nulrp_back.sv
// ----------------------------------------------------------------------------
// nulrp_back
// walks the nested grammar one token a beat and registers the result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nulrp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  nulrp_pkg::token_t head_tok,
  output logic              pop,
  nulrp_out_if.source       out_chan
);
  import nulrp_pkg::*;

  typedef enum logic [1:0] {
    LVL_DELTA  = 2'd0,
    LVL_KIND   = 2'd1,
    LVL_TARGET = 2'd2,
    LVL_PAIR   = 2'd3
  } level_t;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] pairs;
    logic [63:0] targets;
    logic [63:0] kinds;
    logic [63:0] deltas;
  } walk_t;

  // step to the next open item, starting at the given nesting level
  function automatic walk_t walk_on(input level_t lvl, input walk_t w);
    walk_t r;
    r = w;
    if (lvl == LVL_DELTA && w.deltas != '0) begin
      r.deltas = w.deltas - 64'd1;
      r.phase  = PH_SRC_DELTA;
    end else if (lvl <= LVL_KIND && w.kinds != '0) begin
      r.kinds = w.kinds - 64'd1;
      r.phase = PH_KIND;
    end else if (lvl <= LVL_TARGET && w.targets != '0) begin
      r.targets = w.targets - 64'd1;
      r.phase   = PH_TGT_DELTA;
    end else if (w.pairs != '0) begin
      r.pairs = w.pairs - 64'd1;
      r.phase = PH_SRC_SECT;
    end else begin
      r.phase = PH_DONE;
    end
    return r;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic        closed_r, closed_nxt;
  logic [63:0] pairs_r, targets_r, kinds_r, deltas_r;
  logic [7:0]  src_sect_r, src_sect_nxt, tgt_sect_r, tgt_sect_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [63:0] src_off_r, src_off_nxt, tgt_off_r, tgt_off_nxt;
  walk_t       w_cur, w_nxt;
  status_t     status;
  logic        entry;
  logic        load;

  logic        ov_r, ov_nxt;
  logic        o_has_r;
  status_t     o_status_r;
  logic [3:0]  o_kind_r;
  logic [7:0]  o_ssect_r, o_tsect_r;
  logic [63:0] o_soff_r, o_toff_r;

  assign pop = head_valid && (!ov_r || out_chan.ready);

  assign w_cur = '{phase: phase_r, pairs: pairs_r, targets: targets_r,
                   kinds: kinds_r, deltas: deltas_r};

  always_comb begin
    w_nxt        = w_cur;
    closed_nxt   = closed_r;
    src_sect_nxt = src_sect_r;
    tgt_sect_nxt = tgt_sect_r;
    kind_nxt     = kind_r;
    src_off_nxt  = src_off_r;
    tgt_off_nxt  = tgt_off_r;
    status       = ST_RUNNING;
    entry        = 1'b0;
    load         = 1'b0;
    if (pop && !closed_r) begin
      if (head_tok.marker) begin
        if (head_tok.marker_ok) begin
          w_nxt.phase = PH_PAIR_COUNT;
        end else begin
          status = ST_NO_MARKER;
        end
      end else if (head_tok.overflow) begin
        status = ST_MALFORMED;
      end else if (head_tok.num_done) begin
        unique case (phase_r)
          PH_PAIR_COUNT: begin
            w_nxt.pairs = head_tok.value;
            w_nxt       = walk_on(LVL_PAIR, w_nxt);
          end
          PH_SRC_SECT: begin
            src_sect_nxt = head_tok.value[7:0];
            w_nxt.phase  = PH_TGT_SECT;
          end
          PH_TGT_SECT: begin
            tgt_sect_nxt = head_tok.value[7:0];
            w_nxt.phase  = PH_TGT_COUNT;
          end
          PH_TGT_COUNT: begin
            w_nxt.targets = head_tok.value;
            tgt_off_nxt   = '0;
            w_nxt         = walk_on(LVL_TARGET, w_nxt);
          end
          PH_TGT_DELTA: begin
            tgt_off_nxt = tgt_off_r + head_tok.value;
            w_nxt.phase = PH_KIND_COUNT;
          end
          PH_KIND_COUNT: begin
            w_nxt.kinds = head_tok.value;
            w_nxt       = walk_on(LVL_KIND, w_nxt);
          end
          PH_KIND: begin
            if (head_tok.value > KIND_MAX) begin
              status = ST_BAD_KIND;
            end else begin
              kind_nxt    = head_tok.value[3:0];
              w_nxt.phase = PH_DELTA_COUNT;
            end
          end
          PH_DELTA_COUNT: begin
            w_nxt.deltas = head_tok.value;
            src_off_nxt  = '0;
            w_nxt        = walk_on(LVL_DELTA, w_nxt);
          end
          PH_SRC_DELTA: begin
            src_off_nxt = src_off_r + head_tok.value;
            entry       = 1'b1;
            w_nxt       = walk_on(LVL_DELTA, w_nxt);
          end
          default: begin
          end
        endcase
      end
      if (status == ST_RUNNING && w_nxt.phase == PH_DONE) begin
        status = ST_FINISHED;
      end
      if (status == ST_RUNNING && head_tok.last) begin
        status = ST_MALFORMED;
      end
      load       = entry || (status != ST_RUNNING);
      closed_nxt = (status != ST_RUNNING);
    end
    // end of stream re-arms, whether handled or ignored
    if (pop && head_tok.last) begin
      w_nxt.phase = PH_MARKER;
      closed_nxt  = 1'b0;
    end
    phase_nxt = w_nxt.phase;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MARKER;
      closed_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      closed_r <= closed_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pairs_r    <= w_nxt.pairs;
    targets_r  <= w_nxt.targets;
    kinds_r    <= w_nxt.kinds;
    deltas_r   <= w_nxt.deltas;
    src_sect_r <= src_sect_nxt;
    tgt_sect_r <= tgt_sect_nxt;
    kind_r     <= kind_nxt;
    src_off_r  <= src_off_nxt;
    tgt_off_r  <= tgt_off_nxt;
    if (load) begin
      o_has_r    <= entry;
      o_status_r <= status;
      o_kind_r   <= entry ? kind_nxt : 4'd0;
      o_ssect_r  <= entry ? src_sect_nxt : 8'd0;
      o_tsect_r  <= entry ? tgt_sect_nxt : 8'd0;
      o_soff_r   <= entry ? src_off_nxt : 64'd0;
      o_toff_r   <= entry ? tgt_off_nxt : 64'd0;
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.has_entry      = o_has_r;
  assign out_chan.status         = o_status_r;
  assign out_chan.ref_kind       = o_kind_r;
  assign out_chan.source_section = o_ssect_r;
  assign out_chan.target_section = o_tsect_r;
  assign out_chan.source_offset  = o_soff_r;
  assign out_chan.target_offset  = o_toff_r;

endmodule

>>> src/nested_uleb128_reference_parser.sv
// ----------------------------------------------------------------------------
// nested_uleb128_reference_parser
// parses a marker-led nested uleb128 reference stream into entry beats
// ----------------------------------------------------------------------------
// in_chan carries one stream byte a beat with a last-byte flag. out_chan
// carries a beat for each completed source delta (has_entry set) and for
// each terminal status (finished, marker missing, malformed number, bad
// kind); both may share one beat. Bytes that complete nothing give no beat.
// One byte is taken every cycle unless the queue is full; result beats are
// registered. The front assembles numbers and the back walks the grammar,
// one token a cycle unless stalled, with a two-entry token queue between.
// After a terminal status later bytes are dropped until a last byte, which
// always re-arms the parser to wait for the format marker.
// Reset leaves the parser waiting for the marker with nothing queued.
// When the receiver stalls, the result beat holds in the output register,
// the back stops, the queue fills, and in_chan.ready falls once it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nested_uleb128_reference_parser_defines.svh"

module nested_uleb128_reference_parser #(
  parameter int QueueDepth = nulrp_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  nulrp_in_if.sink     in_chan,
  nulrp_out_if.source  out_chan
);
  import nulrp_pkg::*;

  token_t tok, head_tok;
  logic   tok_push, q_not_full, head_valid, q_pop, front_expect;

  nulrp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .q_ready       (q_not_full),
    .tok_push      (tok_push),
    .tok           (tok),
    .expect_marker (front_expect)
  );

  nulrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tok_push),
    .push_tok   (tok),
    .not_full   (q_not_full),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (q_pop)
  );

  nulrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

  `NULRP_ASSERT_IMPL(a_beat_has_cause, clk, rst_n, out_chan.valid && !out_chan.has_entry, out_chan.status != ST_RUNNING, "result beat with neither entry nor status")
  `NULRP_ASSERT_IMPL(a_blank_fields, clk, rst_n, out_chan.valid && !out_chan.has_entry, out_chan.source_offset == 64'd0 && out_chan.target_offset == 64'd0 && out_chan.ref_kind == 4'd0, "status-only beat carries entry fields")
  `NULRP_ASSERT_IMPL(a_last_queued, clk, rst_n, in_chan.valid && in_chan.ready && in_chan.last_byte, tok_push, "last byte not passed to the back")
  `NULRP_ASSERT_NEXT(a_rearm, clk, rst_n, in_chan.valid && in_chan.ready && in_chan.last_byte, front_expect, "front not re-armed after last byte")

endmodule
